// File: rtl/core/safety_timeout_output_bank_core_assert.svh
// Assertion macros for the safety timeout output bank.
// Used by the checker module; expects clk_i and rst_ni in scope.
`ifndef SAFETY_TIMEOUT_OUTPUT_BANK_CORE_ASSERT_SVH
`define SAFETY_TIMEOUT_OUTPUT_BANK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define STOB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stob assertion failed");

// Next-cycle implication, disabled while in reset.
`define STOB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stob assertion failed");

`endif

// File: rtl/core/stob_pkg.sv
// Shared types and constants for the safety timeout output bank.
// No dependencies.
package stob_pkg;

  localparam int PUMP_COUNT    = 8;
  localparam int CHANNEL_COUNT = 16;
  localparam int TICK_W        = 24;
  localparam int UNIT_W        = 3;
  localparam int MASK_W        = 16;
  // channel numbers up to 7 + 8 fit in 7 bits, as does CHANNEL_COUNT up to 64
  localparam int SUM_W         = 7;
  localparam int MASK_CH       = (CHANNEL_COUNT < MASK_W) ? CHANNEL_COUNT : MASK_W;
  localparam int CFG_IDX_W     = 1;

  localparam logic [TICK_W-1:0] DEFAULT_TIMEOUT = TICK_W'(30000);

  localparam logic OP_COMMAND   = 1'b0;
  localparam logic OP_TICK      = 1'b1;
  localparam logic REPORT_TICK  = 1'b0;
  localparam logic REPORT_DONE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PUMP_DEFAULT,
    CFG_VALVE_DEFAULT
  } cfg_idx_e;

  typedef struct packed {
    logic              operation;
    logic              is_valve;
    logic [UNIT_W-1:0] unit_number;
    logic              switch_on;
    logic [TICK_W-1:0] timeout_ticks;
    logic [15:0]       command_code;
    logic [7:0]        logical_device;
  } in_word_t;

  typedef struct packed {
    logic              report_kind;
    logic [15:0]       done_code;
    logic [7:0]        done_device;
    logic [MASK_W-1:0] output_mask;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;      // apply the input word and capture its result
  } stob_cmd_t;

endpackage

// File: rtl/core/safety_timeout_output_bank_core.sv
// Safety timeout output bank, top level: controller plus datapath.
// Depends on stob_pkg, stob_ctrl, stob_datapath.
//
//   channel  direction  handshake                 word
//   in       sink       in_valid_i / in_ready_o   in_word_t  (command or tick)
//   out      source     out_valid_o / out_ready_i out_word_t (report + mask)
//   cfg      sink       cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// All channel countdowns have their own decrementer, so a tick or a command
// updates the bank at the accepting edge. Throughput is one word per cycle
// while the output is drained; the output register is refilled in the
// cycle it is drained. Reset clears all countdowns and outputs at once and
// loads both default timeouts with 30000. A stalled output holds back input.
module safety_timeout_output_bank_core
  import stob_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  cfg_idx_e          cfg_index_i,
  input  logic [TICK_W-1:0] cfg_data_i
);

  stob_cmd_t cmd;

  // output register occupancy and execute strobe
  stob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // countdowns, on bits, defaults and result register
  stob_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_word_o  (out_word_o)
  );

endmodule

// File: rtl/core/stob_ctrl.sv
// Handshake controller: tracks the output register and issues execute strobes.
// Depends on stob_pkg.
module stob_ctrl
  import stob_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output stob_cmd_t cmd_o
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // room when the output register is empty or is drained this cycle
  assign in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_o.exec  = accept;
  assign out_valid_o = (state_q == ST_FULL);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (accept) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (accept) state_d = ST_FULL;
        else if (out_ready_i) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/stob_datapath.sv
// Datapath: default registers, per-channel countdowns, on bits, result register.
// Depends on stob_pkg.
module stob_datapath
  import stob_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stob_cmd_t         cmd_i,
  input  in_word_t          in_word_i,
  input  logic              cfg_we_i,
  input  cfg_idx_e          cfg_index_i,
  input  logic [TICK_W-1:0] cfg_data_i,
  output out_word_t         out_word_o
);

  logic [TICK_W-1:0]        pump_dflt_q, valve_dflt_q;
  logic [TICK_W-1:0]        remaining_q [CHANNEL_COUNT];
  logic [TICK_W-1:0]        remaining_d [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] on_q, on_d;
  out_word_t                out_q, out_d;

  logic [SUM_W-1:0]  ch_sum;
  logic              ch_ok;
  logic [TICK_W-1:0] pick;
  logic [TICK_W-1:0] load_val;
  logic [MASK_W-1:0] mask;

  always_comb begin
    ch_sum = in_word_i.is_valve ? SUM_W'(in_word_i.unit_number) + SUM_W'(PUMP_COUNT)
                                : SUM_W'(in_word_i.unit_number);
    ch_ok  = in_word_i.is_valve ? (ch_sum < SUM_W'(CHANNEL_COUNT))
                                : (ch_sum < SUM_W'(PUMP_COUNT));
    pick     = in_word_i.is_valve ? valve_dflt_q : pump_dflt_q;
    load_val = (in_word_i.timeout_ticks != '0) ? in_word_i.timeout_ticks : pick;
    if (load_val == '0) load_val = TICK_W'(1);
  end

  // one decrementer per channel
  always_comb begin
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      remaining_d[i] = remaining_q[i];
      on_d[i]        = on_q[i];
      if (in_word_i.operation == OP_TICK) begin
        if (remaining_q[i] != '0) begin
          remaining_d[i] = remaining_q[i] - TICK_W'(1);
          if (remaining_q[i] == TICK_W'(1)) on_d[i] = 1'b0;
        end
      end else if (ch_ok && (ch_sum == SUM_W'(i))) begin
        remaining_d[i] = in_word_i.switch_on ? load_val : '0;
        on_d[i]        = in_word_i.switch_on;
      end
    end
  end

  always_comb begin
    mask = '0;
    for (int i = 0; i < MASK_CH; i++) mask[i] = on_d[i];
    out_d.output_mask = mask;
    if (in_word_i.operation == OP_TICK) begin
      out_d.report_kind = REPORT_TICK;
      out_d.done_code   = '0;
      out_d.done_device = '0;
    end else begin
      out_d.report_kind = REPORT_DONE;
      out_d.done_code   = in_word_i.command_code;
      out_d.done_device = in_word_i.logical_device;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pump_dflt_q  <= DEFAULT_TIMEOUT;
      valve_dflt_q <= DEFAULT_TIMEOUT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PUMP_DEFAULT:  pump_dflt_q  <= cfg_data_i;
        CFG_VALVE_DEFAULT: valve_dflt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) remaining_q[i] <= '0;
    end else if (cmd_i.exec) begin
      on_q <= on_d;
      for (int i = 0; i < CHANNEL_COUNT; i++) remaining_q[i] <= remaining_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) out_q <= out_d;
  end

  assign out_word_o = out_q;

endmodule

// File: rtl/core/stob_checker.sv
// Port-level checks for the safety timeout output bank, bound to the top.
// Depends on stob_pkg and safety_timeout_output_bank_core_assert.svh.
`include "safety_timeout_output_bank_core_assert.svh"

module stob_checker
  import stob_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input in_word_t          in_word_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input out_word_t         out_word_o
);

  logic in_acc;
  logic tick_acc;

  assign in_acc   = in_valid_i && in_ready_o;
  assign tick_acc = in_acc && (in_word_i.operation == OP_TICK);

  // an accepted word always yields a result next cycle
`STOB_ASSERT_NEXT(a_result_follows, in_acc, out_valid_o)

  // a blocked result holds back the input side
`STOB_ASSERT_NOW(a_stall_blocks_in, out_valid_o && !out_ready_i, !in_ready_o)

  // a tick reports status only, with zero echo fields
`STOB_ASSERT_NEXT(a_tick_report, tick_acc,
    out_word_o.report_kind == REPORT_TICK && out_word_o.done_code == '0 &&
    out_word_o.done_device == '0)

  // stalled result stays put
`STOB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_word_o))

endmodule

bind safety_timeout_output_bank_core stob_checker u_stob_checker (.*);

// File: dv/tb_safety_timeout_output_bank_core.sv
// Testbench for safety_timeout_output_bank_core: directed table, then random phases.
// Depends on stob_pkg and the core RTL; self-checking against an in-file bank predictor.
`timescale 1ns / 1ps

module tb_safety_timeout_output_bank_core;
  import stob_pkg::*;

  // Cycles with no word moving on either channel before the run is called hung.
  // The long output hold-off lasts HOLD_CYCLES.
  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 400;  // input words accepted before the hold-off

  // ---------------------------------------------------------------------------
  // DUT inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  in_word_t          in_word_i   = '0;
  logic              out_ready_i = 1'b0;
  logic              cfg_we_i    = 1'b0;
  cfg_idx_e          cfg_index_i = CFG_PUMP_DEFAULT;
  logic [TICK_W-1:0] cfg_data_i  = '0;

  logic              in_ready_o;
  logic              out_valid_o;
  out_word_t         out_word_o;

  safety_timeout_output_bank_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the bank and its two default registers
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0] bank_remaining [CHANNEL_COUNT];
  logic              bank_on        [CHANNEL_COUNT];
  logic [TICK_W-1:0] pump_dflt;
  logic [TICK_W-1:0] valve_dflt;

  out_word_t reports_due [$];  // expected output words, oldest first
  int        mismatch_count = 0;
  int        words_in       = 0;

  // Payload companions: a directed row may carry a typed-in report that
  // replaces the predicted one. They travel with the word, so the scoreboard
  // picks them up at the accepting edge.
  logic      row_fixed  = 1'b0;
  out_word_t row_report = '0;

  // Sender and receiver both idle at random unless calm is set.
  bit calm = 1'b0;

  // Applies one word to the predicted bank and returns the report it causes.
  function automatic out_word_t next_report(input in_word_t w);
    out_word_t         r;
    int                ch;
    logic [TICK_W-1:0] load;
    r = '0;
    if (w.operation == OP_TICK) begin
      // every running countdown steps down; hitting zero drops the output
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        if (bank_remaining[i] != '0) begin
          bank_remaining[i] = bank_remaining[i] - 1'b1;
          if (bank_remaining[i] == '0) bank_on[i] = 1'b0;
        end
      end
      r.report_kind = REPORT_TICK;
    end else begin
      ch = w.is_valve ? int'(w.unit_number) + PUMP_COUNT : int'(w.unit_number);
      // out-of-range units leave the bank alone but still report done
      if (ch < CHANNEL_COUNT && (w.is_valve || int'(w.unit_number) < PUMP_COUNT)) begin
        if (w.switch_on) begin
          load = w.timeout_ticks;
          if (load == '0) load = w.is_valve ? valve_dflt : pump_dflt;
          if (load == '0) load = TICK_W'(1);  // zero default still times out
          bank_remaining[ch] = load;
          bank_on[ch]        = 1'b1;
        end else begin
          bank_remaining[ch] = '0;
          bank_on[ch]        = 1'b0;
        end
      end
      r.report_kind = REPORT_DONE;
      r.done_code   = w.command_code;
      r.done_device = w.logical_device;
    end
    for (int i = 0; i < MASK_CH; i++) r.output_mask[i] = bank_on[i];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: pop on output accept first, then push on input accept, so an
  // unexpected report can never pair up with a word taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (reports_due.size() == 0) begin
          flag_mismatch("unexpected report, mask", 32'(out_word_o.output_mask), 32'h0);
        end else begin
          want = reports_due.pop_front();
          if (out_word_o.report_kind !== want.report_kind)
            flag_mismatch("report_kind", 32'(out_word_o.report_kind), 32'(want.report_kind));
          if (out_word_o.done_code !== want.done_code)
            flag_mismatch("done_code", 32'(out_word_o.done_code), 32'(want.done_code));
          if (out_word_o.done_device !== want.done_device)
            flag_mismatch("done_device", 32'(out_word_o.done_device), 32'(want.done_device));
          if (out_word_o.output_mask !== want.output_mask)
            flag_mismatch("output_mask", 32'(out_word_o.output_mask), 32'(want.output_mask));
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = next_report(in_word_i);  // always run, keeps the bank in step
        if (row_fixed) want = row_report;
        reports_due.push_back(want);
        words_in++;
      end
    end
  end

  // Watchdog: any cycle with no word moving counts toward the limit.
  int stuck_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus one long hold-off once traffic is flowing so
  // the output register fills and the block backs up its input.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (!hold_done && words_in >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 15);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge where the word was
  // taken. Valid only drops for an idle gap, never between back-to-back words.
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w, input logic fixed, input out_word_t rep);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    row_fixed  <= fixed;
    row_report <= rep;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // Waits for every outstanding report, always past a clock edge first so the last
  // accepted word has been booked.
  task automatic wait_drained();
    do @(posedge clk_i); while (reports_due.size() != 0);
  endtask

  // Both defaults, back to back; only while the bank is idle.
  task automatic write_defaults(input logic [TICK_W-1:0] pump, input logic [TICK_W-1:0] valve);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PUMP_DEFAULT;
    cfg_data_i  <= pump;
    @(posedge clk_i);
    cfg_index_i <= CFG_VALVE_DEFAULT;
    cfg_data_i  <= valve;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pump_dflt  = pump;
    valve_dflt = valve;
  endtask

  function automatic in_word_t cmd_word(input logic valve, input int unit, input logic on,
                                        input int ticks, input int code, input int dev);
    in_word_t w;
    w.operation      = OP_COMMAND;
    w.is_valve       = valve;
    w.unit_number    = UNIT_W'(unit);
    w.switch_on      = on;
    w.timeout_ticks  = TICK_W'(ticks);
    w.command_code   = 16'(code);
    w.logical_device = 8'(dev);
    return w;
  endfunction

  // Mostly commands with a spread of timeouts: zero (default), short ones that expire
  // under the ticks, medium ones up to 100 and full-width ones. Ticks carry random junk.
  function automatic in_word_t random_word();
    in_word_t w;
    w.operation      = ($urandom_range(99) < 35) ? OP_TICK : OP_COMMAND;
    w.is_valve       = 1'($urandom_range(1));
    w.unit_number    = UNIT_W'($urandom_range(7));
    w.switch_on      = ($urandom_range(99) < 65);
    case ($urandom_range(3))
      0:       w.timeout_ticks = '0;
      1:       w.timeout_ticks = TICK_W'($urandom_range(6, 1));
      2:       w.timeout_ticks = TICK_W'($urandom_range(100, 7));
      default: w.timeout_ticks = TICK_W'($urandom);
    endcase
    w.command_code   = 16'($urandom);
    w.logical_device = 8'($urandom);
    return w;
  endfunction

  typedef struct {
    in_word_t  word;
    logic      fixed;
    out_word_t rep;
  } plan_row_t;

  typedef struct {
    bit                write;
    logic [TICK_W-1:0] pump;
    logic [TICK_W-1:0] valve;
    bit                quiet;
    int                items;
  } phase_t;

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t plan [$];
    phase_t    phases [$];

    pump_dflt  = DEFAULT_TIMEOUT;
    valve_dflt = DEFAULT_TIMEOUT;
    for (int i = 0; i < CHANNEL_COUNT; i++) begin
      bank_remaining[i] = '0;
      bank_on[i]        = 1'b0;
    end

    // Directed rows. Typed reports where the bank state is obvious; channel
    // numbering: pumps 0..7 in the low mask bits, valves 0..7 above them.
    // tick with every other field set: fields ignored, report zeroed
    plan.push_back('{'{OP_TICK, 1'b1, 3'h7, 1'b1, 24'hFFFFFF, 16'hFFFF, 8'hFF}, 1'b1,
                     '{REPORT_TICK, 16'h0000, 8'h00, 16'h0000}});
    // off to an idle pump, all-ones payload
    plan.push_back('{cmd_word(1'b0, 0, 1'b0, 24'hFFFFFF, 16'hFFFF, 8'hFF), 1'b1,
                     '{REPORT_DONE, 16'hFFFF, 8'hFF, 16'h0000}});
    plan.push_back('{cmd_word(1'b0, 0, 1'b1, 2, 0, 0), 1'b1,
                     '{REPORT_DONE, 16'h0000, 8'h00, 16'h0001}});
    // zero timeout picks the valve default (reset value, far away)
    plan.push_back('{cmd_word(1'b1, 7, 1'b1, 0, 16'h1234, 8'h56), 1'b1,
                     '{REPORT_DONE, 16'h1234, 8'h56, 16'h8001}});
    plan.push_back('{'{OP_TICK, 1'b0, 3'h0, 1'b0, 24'h0, 16'h0, 8'h0}, 1'b1,
                     '{REPORT_TICK, 16'h0000, 8'h00, 16'h8001}});
    // pump 0 countdown expires silently
    plan.push_back('{'{OP_TICK, 1'b0, 3'h0, 1'b0, 24'h0, 16'h0, 8'h0}, 1'b1,
                     '{REPORT_TICK, 16'h0000, 8'h00, 16'h8000}});
    plan.push_back('{cmd_word(1'b0, 7, 1'b1, 24'hFFFFFF, 16'hAAAA, 8'h55), 1'b1,
                     '{REPORT_DONE, 16'hAAAA, 8'h55, 16'h8080}});
    // restart a running channel with a short reload
    plan.push_back('{cmd_word(1'b0, 7, 1'b1, 1, 16'h5555, 8'hAA), 1'b1,
                     '{REPORT_DONE, 16'h5555, 8'hAA, 16'h8080}});
    plan.push_back('{'{OP_TICK, 1'b1, 3'h5, 1'b1, 24'h0, 16'h0, 8'h0}, 1'b1,
                     '{REPORT_TICK, 16'h0000, 8'h00, 16'h8000}});
    plan.push_back('{cmd_word(1'b1, 7, 1'b0, 0, 16'h0001, 8'h01), 1'b1,
                     '{REPORT_DONE, 16'h0001, 8'h01, 16'h0000}});
    // predictor-checked from here on
    plan.push_back('{cmd_word(1'b1, 0, 1'b1, 3, 16'h0BAD, 8'h10), 1'b0, '0});
    plan.push_back('{cmd_word(1'b1, 0, 1'b1, 0, 16'h0C0D, 8'h11), 1'b0, '0});
    plan.push_back('{cmd_word(1'b0, 3, 1'b1, 1, 16'h8000, 8'h80), 1'b0, '0});
    plan.push_back('{cmd_word(1'b1, 4, 1'b1, 2, 16'h7FFF, 8'h7F), 1'b0, '0});
    plan.push_back('{'{OP_TICK, 1'b0, 3'h2, 1'b1, 24'h123456, 16'hBEEF, 8'h42}, 1'b0, '0});
    plan.push_back('{'{OP_TICK, 1'b0, 3'h0, 1'b0, 24'h0, 16'h0, 8'h0}, 1'b0, '0});
    plan.push_back('{cmd_word(1'b1, 0, 1'b0, 24'h800000, 16'h0002, 8'h02), 1'b0, '0});
    plan.push_back('{cmd_word(1'b0, 3, 1'b0, 5, 16'h0003, 8'h03), 1'b0, '0});
    plan.push_back('{'{OP_TICK, 1'b1, 3'h7, 1'b0, 24'h0, 16'h0, 8'h0}, 1'b0, '0});

    // Default settings per phase: reset values, both extremes each way, zero
    // (load forced to one), small values that expire, and a random pair.
    phases.push_back('{1'b0, DEFAULT_TIMEOUT, DEFAULT_TIMEOUT, 1'b0, 250});
    phases.push_back('{1'b1, 24'd1, 24'hFFFFFF, 1'b0, 300});
    phases.push_back('{1'b1, 24'd0, 24'd0, 1'b0, 300});
    phases.push_back('{1'b1, 24'hFFFFFF, 24'd1, 1'b1, 300});  // no idling at all
    phases.push_back('{1'b1, 24'd3, 24'd5, 1'b0, 300});
    phases.push_back('{1'b1, TICK_W'($urandom_range(40, 1)), TICK_W'($urandom_range(40, 1)),
                       1'b0, 300});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_word(plan[i].word, plan[i].fixed, plan[i].rep);
    in_valid_i <= 1'b0;
    row_fixed  <= 1'b0;

    foreach (phases[p]) begin
      wait_drained();  // registers only change with the bank idle
      if (phases[p].write) write_defaults(phases[p].pump, phases[p].valve);
      calm = phases[p].quiet;
      repeat (phases[p].items) send_word(random_word(), 1'b0, '0);
      in_valid_i <= 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);  // catch any stray report after the last one
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/stob_pkg.sv
rtl/core/stob_ctrl.sv
rtl/core/stob_datapath.sv
rtl/core/safety_timeout_output_bank_core.sv
rtl/core/stob_checker.sv
dv/tb_safety_timeout_output_bank_core.sv
